// File: rtl/dlq_pkg.sv
// shared types, codes and defaults for the delta-list timer queue
`timescale 1ns / 1ps
`default_nettype none
package dlq_pkg;

   localparam int DEF_MAX_ENTRIES = 32;
   localparam int DEF_TICK_MS     = 10;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   // transaction kinds on req_tuser
   localparam logic [1:0] KIND_ADD      = 2'd0;
   localparam logic [1:0] KIND_TICK     = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;
   localparam logic [1:0] KIND_DELETE   = 2'd3;

   // operations broadcast to the row of cells
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_TICK   = 2'd3;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [31:0] delta;
      logic [31:0] period;
      logic [7:0]  runs;
   } entry_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  task_id;
      logic [31:0] period;
      logic [31:0] left;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: rtl/dlq_cell.sv
// one list entry; shifts to or from its neighbors on insert and remove
`timescale 1ns / 1ps
`default_nettype none
module dlq_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 5
) (
   input  logic                 clock,
   input  dlq_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]        slot,
   input  dlq_pkg::entry_type   prev,
   input  dlq_pkg::entry_type   next,
   output dlq_pkg::entry_type   ent
);
   import dlq_pkg::*;

   entry_type   ent_ff, ent_in;
   logic        at_slot, after_slot, past_slot;
   logic [31:0] dec;

   assign at_slot    = (slot == IW'(INDEX));
   assign after_slot = (INDEX > 0) && (slot == IW'(INDEX - 1));
   assign past_slot  = (IW'(INDEX) > slot);
   assign dec        = (ent_ff.delta != 32'd0) ? ent_ff.delta - 32'd1 : 32'd0;

   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (at_slot) begin
               ent_in.task_id = cmd.task_id;
               ent_in.delta   = cmd.left;
               ent_in.period  = cmd.period;
               ent_in.runs    = 8'd0;
            end else if (past_slot) begin
               ent_in = prev;
               // entry right behind the new one loses the new entry's delta
               if (after_slot) begin
                  ent_in.delta = prev.delta - cmd.left;
               end
            end
         end
         CELL_REMOVE: begin
            if (at_slot) begin
               ent_in       = next;
               ent_in.delta = next.delta + ent_ff.delta;
            end else if (past_slot) begin
               ent_in = next;
            end
         end
         CELL_TICK: begin
            if (INDEX == 0) begin
               ent_in.delta = dec;
               if (dec == 32'd0 && ent_ff.runs != 8'hFF) begin
                  ent_in.runs = ent_ff.runs + 8'd1;
               end
            end
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule
`default_nettype wire

// File: rtl/dlq_div.sv
// pipelined divide by the tick length: reciprocal multiply and one correction
`timescale 1ns / 1ps
`default_nettype none
module dlq_div #(
   parameter int TICK_MS = dlq_pkg::DEF_TICK_MS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] x,
   output logic        done,
   output logic [31:0] q
);
   import dlq_pkg::*;

   localparam int          TW    = $clog2(TICK_MS + 1);
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICK_MS);
   localparam logic [TW-1:0] TICK = TW'(TICK_MS);

   logic        v1_ff, v2_ff, done_ff;
   logic [64:0] prod_ff;
   logic [31:0] x1_ff, x2_ff, qe_ff, q_ff, q_in, rem;
   logic [31:0] back_ff;
   logic [TW+31:0] back_full;

   function automatic logic [TW+31:0] qe_in_mul(input logic [31:0] a);
      qe_in_mul = a * TICK;
   endfunction

   // estimate is never above the quotient and at most one below it
   assign back_full = qe_in_mul(prod_ff[63:32]);
   assign rem       = x2_ff - back_ff;
   assign q_in      = (rem >= 32'(TICK)) ? qe_ff + 32'd1 : qe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= x * RECIP;
      x1_ff   <= x;
      qe_ff   <= prod_ff[63:32];
      back_ff <= back_full[31:0];
      x2_ff   <= x1_ff;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule
`default_nettype wire

// File: rtl/delta_list_timer_queue.sv
// top level: sequencer, row of entry cells and result register
`timescale 1ns / 1ps
`default_nettype none
// Delta-list timer queue. Entries sit in a row of cells sorted by due time;
// each holds its delay in ticks relative to the entry ahead, so a tick only
// touches the head. Every request returns exactly one response. Add, and a
// dispatch of a periodic task, convert milliseconds to ticks in a 3-stage
// divider and then walk the list one cell per cycle to find the slot. In the
// shift, the cell at the slot and every cell past it load their new entries
// together. One request is in flight at a time.
module delta_list_timer_queue #(
   parameter int MAX_ENTRIES = dlq_pkg::DEF_MAX_ENTRIES,
   parameter int TICK_MS     = dlq_pkg::DEF_TICK_MS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_id[7:0], delay_ms[39:8], period_ms[71:40], entry_index[76:72], zeros
   input  logic [dlq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // ran[0], ran_task_id[8:1], status[9], task_count[15:10]
   output logic [dlq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import dlq_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_INS  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    id_ff, id_in;
   logic [31:0]   delay_ff, delay_in;
   logic [31:0]   period_ff, period_in;
   logic [4:0]    idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic [31:0]   left_ff, left_in;
   logic          ran_ff, ran_in;
   logic [7:0]    ran_id_ff, ran_id_in;
   logic          status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_cmd_type  cmd;
   logic [IW-1:0] slot;
   logic          div_start, div_done;
   logic [31:0]   div_x, div_q;
   logic [31:0]   walk_delta;
   logic          idx_ok;

   entry_type ent [MAX_ENTRIES];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         entry_type prev_ent, next_ent;
         if (gi == 0) begin : g_first
            assign prev_ent = '0;
         end else begin : g_mid_prev
            assign prev_ent = ent[gi-1];
         end
         if (gi == MAX_ENTRIES - 1) begin : g_last
            assign next_ent = '0;
         end else begin : g_mid_next
            assign next_ent = ent[gi+1];
         end
         dlq_cell #(
            .INDEX (gi),
            .IW    (IW)
         ) u_cell (
            .clock (clock),
            .cmd   (cmd),
            .slot  (slot),
            .prev  (prev_ent),
            .next  (next_ent),
            .ent   (ent[gi])
         );
      end
   endgenerate

   dlq_div #(
      .TICK_MS (TICK_MS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .done  (div_done),
      .q     (div_q)
   );

   assign walk_delta = ent[k_ff[IW-1:0]].delta;
   assign idx_ok     = (XW'(idx_ff) < XW'(count_ff));
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      delay_in     = delay_ff;
      period_in    = period_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      left_in      = left_ff;
      ran_in       = ran_ff;
      ran_id_in    = ran_id_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      cmd.op       = CELL_HOLD;
      slot         = '0;
      div_start    = 1'b0;
      div_x        = delay_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               id_in     = req_tdata[7:0];
               delay_in  = req_tdata[39:8];
               period_in = req_tdata[71:40];
               idx_in    = req_tdata[76:72];
               ran_in    = 1'b0;
               ran_id_in = 8'd0;
               status_in = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (kind_ff)
               KIND_ADD: begin
                  if (count_ff == CW'(MAX_ENTRIES)) begin
                     status_in = 1'b1;
                     state_in  = S_DONE;
                  end else begin
                     div_start = 1'b1;
                     div_x     = delay_ff;
                     state_in  = S_DIV;
                  end
               end
               KIND_TICK: begin
                  if (count_ff != '0) begin
                     cmd.op = CELL_TICK;
                  end
                  state_in = S_DONE;
               end
               KIND_DISPATCH: begin
                  state_in = S_DONE;
                  if (count_ff != '0 && ent[0].runs != 8'd0) begin
                     cmd.op    = CELL_REMOVE;
                     slot      = '0;
                     ran_in    = 1'b1;
                     ran_id_in = ent[0].task_id;
                     count_in  = count_ff - CW'(1);
                     // periodic task goes back in, delayed by its period
                     if (ent[0].period != 32'd0) begin
                        id_in     = ent[0].task_id;
                        period_in = ent[0].period;
                        div_start = 1'b1;
                        div_x     = ent[0].period;
                        state_in  = S_DIV;
                     end
                  end
               end
               KIND_DELETE: begin
                  if (idx_ok) begin
                     cmd.op   = CELL_REMOVE;
                     slot     = IW'(idx_ff);
                     count_in = count_ff - CW'(1);
                  end else begin
                     status_in = 1'b1;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               left_in  = div_q;
               k_in     = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (k_ff == count_ff) begin
               state_in = S_INS;
            end else if (walk_delta <= left_ff) begin
               left_in = left_ff - walk_delta;
               k_in    = k_ff + CW'(1);
            end else begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            cmd.op      = CELL_INSERT;
            cmd.task_id = id_ff;
            cmd.period  = period_ff;
            cmd.left    = left_ff;
            slot        = k_ff[IW-1:0];
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'(count_ff), status_ff, ran_id_ff, ran_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      delay_ff    <= delay_in;
      period_ff   <= period_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      left_ff     <= left_in;
      ran_ff      <= ran_in;
      ran_id_ff   <= ran_id_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/dlq_checker.sv
// port-level checks for the timer queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dlq_checker #(
   parameter int MAX_ENTRIES = dlq_pkg::DEF_MAX_ENTRIES
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [dlq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic [1:0]                      req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [dlq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import dlq_pkg::*;

   // a released task never comes with an error status
   a_ran_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[9])
      else $error("dispatch response carries error status");

   // no task id without a release
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0)
      else $error("task id reported without a release");

   // count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (MAX_ENTRIES < 64) |-> 32'(rsp_tdata[15:10]) <= 32'(MAX_ENTRIES))
      else $error("entry count above capacity");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // the block does not take a new transaction while busy with one
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

endmodule

bind delta_list_timer_queue dlq_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_dlq_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// testbench for the delta-list timer queue: directed table, fill, saturation and random traffic
`timescale 1ns / 1ps
module tb;
   import dlq_pkg::*;

   localparam int         MAX_SLOTS  = DEF_MAX_ENTRIES;
   localparam bit [31:0]  TICK_LEN   = 32'(DEF_TICK_MS);
   localparam int         QUIET_MAX  = 2000;
   localparam int         SETTLE     = 60;
   localparam int         RAND_ITEMS = 160;
   localparam int         NUM_ROWS   = 18;
   localparam bit         ST_OK      = 1'b0;
   localparam bit         ST_REJECT  = 1'b1;

   typedef struct {
      bit [1:0]  kind;
      bit [7:0]  id;
      bit [31:0] delay_ms;
      bit [31:0] period_ms;
      bit [4:0]  idx;
   } sched_req_type;

   typedef struct {
      bit        ran;
      bit [7:0]  ran_id;
      bit        status;
      bit [5:0]  count;
   } sched_rsp_type;

   typedef struct {
      sched_req_type req;
      bit            fixed;
      sched_rsp_type rsp;
   } sched_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_TIGHT, RX_CADENCE} rx_mode_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = KIND_ADD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // predicted list, kept in step with accepted transactions
   bit [7:0]  sl_task   [MAX_SLOTS];
   bit [31:0] sl_delta  [MAX_SLOTS];
   bit [31:0] sl_period [MAX_SLOTS];
   bit [7:0]  sl_runs   [MAX_SLOTS];
   int        sched_count;

   sched_rsp_type rsp_due_q[$];
   sched_rsp_type mon_exp;
   sched_rsp_type mon_act;
   sched_row_type steps[NUM_ROWS];
   int            errors      = 0;
   int            sent_total  = 0;
   int            burst_left  = 0;
   int            quiet       = 0;
   int            stall_left  = 0;
   int            cadence     = 0;
   rx_mode_type   stall_mode  = RX_OPEN;

   delta_list_timer_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit sched_insert(bit [7:0] id, bit [31:0] delay_ms, bit [31:0] period_ms);
      bit [31:0] left;
      int        slot;
      if (sched_count >= MAX_SLOTS) return 1'b0;
      left = delay_ms / TICK_LEN;
      slot = sched_count;
      for (int i = 0; i < sched_count; i++) begin
         if (sl_delta[i] <= left) begin
            left -= sl_delta[i];
         end else begin
            slot = i;
            break;
         end
      end
      for (int i = sched_count; i > slot; i--) begin
         sl_task[i]   = sl_task[i-1];
         sl_delta[i]  = sl_delta[i-1];
         sl_period[i] = sl_period[i-1];
         sl_runs[i]   = sl_runs[i-1];
      end
      sched_count++;
      sl_task[slot]   = id;
      sl_delta[slot]  = left;
      sl_period[slot] = period_ms;
      sl_runs[slot]   = 8'd0;
      if (slot + 1 < sched_count) sl_delta[slot+1] -= left;
      return 1'b1;
   endfunction

   function automatic bit sched_remove(int pos);
      int last;
      if (pos >= sched_count) return 1'b0;
      last = sched_count - 1;
      // removed delay folds into the follower
      if (pos < last) sl_delta[pos+1] += sl_delta[pos];
      for (int i = pos; i < last; i++) begin
         sl_task[i]   = sl_task[i+1];
         sl_delta[i]  = sl_delta[i+1];
         sl_period[i] = sl_period[i+1];
         sl_runs[i]   = sl_runs[i+1];
      end
      sl_task[last]   = 8'd0;
      sl_delta[last]  = 32'd0;
      sl_period[last] = 32'd0;
      sl_runs[last]   = 8'd0;
      sched_count     = last;
      return 1'b1;
   endfunction

   function automatic sched_rsp_type sched_step(sched_req_type r);
      sched_rsp_type o;
      bit [7:0]      tid;
      bit [31:0]     per;
      o = '{1'b0, 8'd0, ST_OK, 6'd0};
      case (r.kind)
         KIND_ADD: begin
            if (!sched_insert(r.id, r.delay_ms, r.period_ms)) o.status = ST_REJECT;
         end
         KIND_TICK: begin
            if (sched_count > 0) begin
               if (sl_delta[0] > 0) sl_delta[0]--;
               if (sl_delta[0] == 0 && sl_runs[0] != 8'hFF) sl_runs[0]++;
            end
         end
         KIND_DISPATCH: begin
            if (sched_count > 0 && sl_runs[0] > 0) begin
               tid      = sl_task[0];
               per      = sl_period[0];
               o.ran    = 1'b1;
               o.ran_id = tid;
               void'(sched_remove(0));
               if (per > 0) void'(sched_insert(tid, per, per));
            end
         end
         default: begin
            if (!sched_remove(int'(r.idx))) o.status = ST_REJECT;
         end
      endcase
      o.count = 6'(sched_count);
      return o;
   endfunction

   // drive one transaction, honoring the burst/gap pattern, and queue its response
   task automatic push_req(input sched_req_type r, input bit fixed,
                           input sched_rsp_type fixed_rsp);
      sched_rsp_type e;
      int            gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {3'b000, r.idx, r.period_ms, r.delay_ms, r.id};
      do @(posedge clock); while (!req_tready);
      e = sched_step(r);
      rsp_due_q.push_back(fixed ? fixed_rsp : e);
      sent_total++;
   endtask

   task automatic send(input bit [1:0] kind, input bit [7:0] id, input bit [31:0] delay_ms,
                       input bit [31:0] period_ms, input bit [4:0] idx);
      sched_req_type r;
      sched_rsp_type none;
      r    = '{kind, id, delay_ms, period_ms, idx};
      none = '{1'b0, 8'd0, ST_OK, 6'd0};
      push_req(r, 1'b0, none);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   function automatic bit [31:0] pick_period();
      int p;
      p = $urandom_range(0, 9);
      if (p < 5) return 32'd0;
      if (p < 9) return 32'($urandom_range(1, 60));
      return $urandom;
   endfunction

   initial begin
      int p;
      int n;
      int rand_base;
      steps[0]  = '{'{KIND_TICK,     8'h00, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[1]  = '{'{KIND_DISPATCH, 8'h00, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[2]  = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b0, 8'h00, ST_REJECT, 6'd0}};
      steps[3]  = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd31}, 1'b1,
                    '{1'b0, 8'h00, ST_REJECT, 6'd0}};
      steps[4]  = '{'{KIND_ADD,      8'hFF, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b0, 8'h00, ST_OK,     6'd1}};
      steps[5]  = '{'{KIND_ADD,      8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31}, 1'b1,
                    '{1'b0, 8'h00, ST_OK,     6'd2}};
      // 9 ms rounds down to zero ticks, lands after the equal head
      steps[6]  = '{'{KIND_ADD,      8'h5A, 32'd9,        32'd25,       5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[7]  = '{'{KIND_ADD,      8'hA5, 32'd10,       32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[8]  = '{'{KIND_DISPATCH, 8'h00, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b0, 8'h00, ST_OK,     6'd4}};
      steps[9]  = '{'{KIND_TICK,     8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[10] = '{'{KIND_DISPATCH, 8'h00, 32'd0,        32'd0,        5'd0},  1'b1,
                    '{1'b1, 8'hFF, ST_OK,     6'd3}};
      steps[11] = '{'{KIND_DISPATCH, 8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[12] = '{'{KIND_TICK,     8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      // periodic head goes back into the list
      steps[13] = '{'{KIND_DISPATCH, 8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[14] = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd1},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[15] = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd3},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[16] = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};
      steps[17] = '{'{KIND_DELETE,   8'h00, 32'd0,        32'd0,        5'd0},  1'b0,
                    '{1'b0, 8'h00, ST_OK,     6'd0}};

      for (int i = 0; i < MAX_SLOTS; i++) begin
         sl_task[i]   = 8'd0;
         sl_delta[i]  = 32'd0;
         sl_period[i] = 32'd0;
         sl_runs[i]   = 8'd0;
      end
      sched_count = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) push_req(steps[i].req, steps[i].fixed, steps[i].rsp);
      drain_all();

      // fill the table, overflow it once, then empty it with deletes
      while (sched_count < MAX_SLOTS)
         send(KIND_ADD, 8'($urandom_range(0, 255)), $urandom, pick_period(), 5'd0);
      send(KIND_ADD, 8'h77, 32'd0, 32'd0, 5'd0);
      send(KIND_DELETE, 8'h00, 32'd0, 32'd0, 5'd31);
      while (sched_count > 0)
         send(KIND_DELETE, 8'h00, 32'd0, 32'd0, 5'($urandom_range(0, sched_count - 1)));

      // 256 ticks on a due head: run count must stick at 255 instead of wrapping
      send(KIND_ADD, 8'h3C, 32'd0, 32'd0, 5'd0);
      repeat (256) send(KIND_TICK, 8'h00, 32'd0, 32'd0, 5'd0);
      send(KIND_DISPATCH, 8'h00, 32'd0, 32'd0, 5'd0);
      send(KIND_DISPATCH, 8'h00, 32'd0, 32'd0, 5'd0);

      rand_base = sent_total;
      while (sent_total - rand_base < RAND_ITEMS) begin
         p = $urandom_range(0, 99);
         if (sched_count >= 24 && p < 60) p = 80;
         if (p < 35) begin
            n = $urandom_range(1, 4);
            repeat (n) send(KIND_ADD, 8'($urandom_range(0, 255)), 32'($urandom_range(0, 80)),
                            pick_period(), 5'($urandom));
         end else if (p < 72) begin
            n = $urandom_range(2, 12);
            repeat (n) begin
               send(KIND_TICK, 8'($urandom), 32'd0, 32'd0, 5'd0);
               if ($urandom_range(0, 9) < 6) send(KIND_DISPATCH, 8'($urandom), 32'd0, 32'd0, 5'd0);
            end
         end else if (p < 86) begin
            if (sched_count > 0 && $urandom_range(0, 4) != 0)
               send(KIND_DELETE, 8'h00, 32'd0, 32'd0, 5'($urandom_range(0, sched_count - 1)));
            else
               send(KIND_DELETE, 8'h00, 32'd0, 32'd0, 5'($urandom));
         end else if (p < 97) begin
            send(2'($urandom), 8'($urandom), $urandom, $urandom, 5'($urandom));
         end else begin
            drain_all();
         end
      end

      req_tvalid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // receiver back-pressure, switching between a few styles
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = rx_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 80);
      end else begin
         stall_left--;
      end
      cadence++;
      case (stall_mode)
         RX_OPEN:  rsp_tready <= 1'b1;
         RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         RX_TIGHT: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:  rsp_tready <= (cadence % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mon_act = '{rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[9], rsp_tdata[15:10]};
         if (rsp_due_q.size() == 0) begin
            $display("%0t: response %h with nothing expected", $time, rsp_tdata);
            errors++;
         end else begin
            mon_exp = rsp_due_q.pop_front();
            if (mon_exp.ran != mon_act.ran) begin
               $display("%0t: ran expected %0d got %0d", $time, mon_exp.ran, mon_act.ran);
               errors++;
            end
            if (mon_exp.ran_id != mon_act.ran_id) begin
               $display("%0t: ran_task_id expected %h got %h", $time, mon_exp.ran_id,
                        mon_act.ran_id);
               errors++;
            end
            if (mon_exp.status != mon_act.status) begin
               $display("%0t: status expected %0d got %0d", $time, mon_exp.status,
                        mon_act.status);
               errors++;
            end
            if (mon_exp.count != mon_act.count) begin
               $display("%0t: task_count expected %0d got %0d", $time, mon_exp.count,
                        mon_act.count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule
